// File: rtl/core/dgf_pkg.sv
// Shared types and constants of the datagram fragmenter.
// Depends on nothing; every file of the block refers to it by scoped names.
package dgf_pkg;

	// Input item codes
	typedef enum logic [1:0] {
		ACT_BEGIN   = 2'd0,
		ACT_ID      = 2'd1,
		ACT_PAYLOAD = 2'd2
	} action_t;

	// Fragment type bytes
	localparam logic [7:0] TYPE_FIRST  = 8'h08;
	localparam logic [7:0] TYPE_MIDDLE = 8'h09;
	localparam logic [7:0] TYPE_LAST   = 8'h0a;

	// Header bytes ahead of the identifier: type, sequence low, sequence high
	localparam int HDR_FIXED = 3;
	// Identifier store depth and its address width
	localparam int ID_DEPTH  = 16;
	localparam int ID_AW     = 4;

	// Input beat
	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  value;
		logic [15:0] msg_length;
	} in_t;

	// Output beat
	typedef struct packed {
		logic [7:0] out_byte;
		logic       datagram_end;
		logic       run_last;
	} out_t;

	// One emit job: optional header, then one payload byte
	typedef struct packed {
		logic        hdr;
		logic [7:0]  frag_type;
		logic [15:0] seq;
		logic [7:0]  data;
		logic        dg_end;
	} job_t;

	// Identifier store write
	typedef struct packed {
		logic             en;
		logic [ID_AW-1:0] addr;
		logic [7:0]       data;
	} id_wr_t;

endpackage

// File: rtl/core/datagram_fragmenter.sv
// Datagram fragmenter top level: control stage feeding the byte emitter.
// Depends on dgf_pkg, dgf_ctl and dgf_emit.
// A payload beat passes the job register, then the output register.
// Throughput: one beat per cycle while result_stall is low; a payload beat
// that opens a fragment gives ID_LEN + 4 results and holds item_stall until
// the last of them is emitted. Reset: arst_n clears enable, message state
// and valids; the identifier store is not cleared.
module datagram_fragmenter #(
	parameter int FRAG_LEN = 512,
	parameter int ID_LEN   = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  dgf_pkg::in_t  item,
	output logic          result_valid,
	input  logic          result_stall,
	output dgf_pkg::out_t result,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_data
);

	logic            job_valid;
	logic            job_done;
	dgf_pkg::job_t   job;
	dgf_pkg::id_wr_t id_wr;

	// Register writes are always taken
	assign cfg_ready = 1'b1;

	dgf_ctl #(
		.FRAG_LEN (FRAG_LEN),
		.ID_LEN   (ID_LEN)
	) u_ctl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.job_done   (job_done),
		.job_valid  (job_valid),
		.job        (job),
		.id_wr      (id_wr)
	);

	dgf_emit #(
		.ID_LEN (ID_LEN)
	) u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (job),
		.id_wr        (id_wr),
		.job_done     (job_done),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// File: rtl/core/dgf_ctl.sv
// Framing control: input handshake, message state and job register.
// Depends on dgf_pkg.
module dgf_ctl #(
	parameter int FRAG_LEN = 512,
	parameter int ID_LEN   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  dgf_pkg::in_t     item,
	input  logic             cfg_valid,
	input  logic             cfg_data,
	input  logic             job_done,
	output logic             job_valid,
	output dgf_pkg::job_t    job,
	output dgf_pkg::id_wr_t  id_wr
);

	localparam int          FILL_W = $clog2(FRAG_LEN + 1);
	localparam int          IDW_W  = $clog2(ID_LEN + 1);
	localparam logic [16:0] TWICE  = 17'(2 * FRAG_LEN);

	logic              send_en_q;
	logic [IDW_W-1:0]  idw_q, idw_d;
	logic [15:0]       rem_q, rem_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [15:0]       seq_q, seq_d;
	logic              frag_q, frag_d;
	logic              job_vld_s1;
	dgf_pkg::job_t     job_s1, job_d;
	logic              job_load;
	logic              acc;
	logic [15:0]       rem_dec;
	logic [FILL_W-1:0] fill_inc;
	logic              seg_end;

	// Hold input while a job still has bytes beyond this cycle
	assign item_stall = job_vld_s1 && !job_done;
	assign acc        = item_valid && !item_stall && send_en_q;
	assign job_valid  = job_vld_s1;
	assign job        = job_s1;

	// Enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_en_q <= 1'b0;
		end else if (cfg_valid) begin
			send_en_q <= cfg_data;
		end
	end

	// Next message state for the accepted beat
	always_comb begin
		idw_d    = idw_q;
		rem_d    = rem_q;
		fill_d   = fill_q;
		seq_d    = seq_q;
		frag_d   = frag_q;
		job_load = 1'b0;
		job_d    = '0;
		id_wr    = '0;
		rem_dec  = rem_q - 16'd1;
		fill_inc = fill_q + FILL_W'(1);
		seg_end  = 1'b0;
		if (acc) begin
			case (item.action)
				dgf_pkg::ACT_BEGIN: begin
					rem_d  = item.msg_length;
					frag_d = {1'b0, item.msg_length} > TWICE;
					fill_d = '0;
					seq_d  = '0;
					idw_d  = '0;
				end
				dgf_pkg::ACT_ID: begin
					if (idw_q < IDW_W'(ID_LEN)) begin
						id_wr.en   = 1'b1;
						id_wr.addr = dgf_pkg::ID_AW'(idw_q);
						id_wr.data = item.value;
						idw_d      = idw_q + IDW_W'(1);
					end
				end
				dgf_pkg::ACT_PAYLOAD: begin
					if (rem_q != 16'd0) begin
						job_load       = 1'b1;
						job_d.hdr      = frag_q && (fill_q == '0);
						job_d.seq      = seq_q;
						job_d.data     = item.value;
						if (seq_q == 16'd0) begin
							job_d.frag_type = dgf_pkg::TYPE_FIRST;
						end else if (rem_q <= 16'(FRAG_LEN)) begin
							job_d.frag_type = dgf_pkg::TYPE_LAST;
						end else begin
							job_d.frag_type = dgf_pkg::TYPE_MIDDLE;
						end
						rem_d = rem_dec;
						if (frag_q) begin
							seg_end = (fill_inc >= FILL_W'(FRAG_LEN)) || (rem_dec == 16'd0);
							fill_d  = seg_end ? '0 : fill_inc;
							seq_d   = seg_end ? seq_q + 16'd1 : seq_q;
						end else begin
							seg_end = (rem_dec == 16'd0);
						end
						job_d.dg_end = seg_end;
						if (rem_dec == 16'd0) begin
							frag_d = 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idw_q  <= '0;
			rem_q  <= '0;
			fill_q <= '0;
			seq_q  <= '0;
			frag_q <= 1'b0;
		end else begin
			idw_q  <= idw_d;
			rem_q  <= rem_d;
			fill_q <= fill_d;
			seq_q  <= seq_d;
			frag_q <= frag_d;
		end
	end

	// Job register: load on a payload beat while bytes remain, drop once emitted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_vld_s1 <= 1'b0;
		end else if (job_load) begin
			job_vld_s1 <= 1'b1;
		end else if (job_done) begin
			job_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_load) begin
			job_s1 <= job_d;
		end
	end

endmodule

// File: rtl/core/dgf_emit.sv
// Byte emitter: identifier store, header sequencing and output register.
// Depends on dgf_pkg.
module dgf_emit #(
	parameter int ID_LEN = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	input  dgf_pkg::job_t   job,
	input  dgf_pkg::id_wr_t id_wr,
	output logic            job_done,
	output logic            result_valid,
	input  logic            result_stall,
	output dgf_pkg::out_t   result
);

	localparam int LAST_POS = ID_LEN + dgf_pkg::HDR_FIXED;
	localparam int POS_W    = $clog2(LAST_POS + 1);

	logic [7:0]       id_store [dgf_pkg::ID_DEPTH];
	logic [POS_W-1:0] pos_q;
	logic [4:0]       id_off;
	logic [7:0]       cur_byte;
	logic             cur_last;
	logic             adv;
	logic             out_vld_s2;
	dgf_pkg::out_t    out_s2;

	assign adv          = !out_vld_s2 || !result_stall;
	assign job_done     = job_valid && cur_last && adv;
	assign result_valid = out_vld_s2;
	assign result       = out_s2;

	// Identifier store writes
	always_ff @(posedge clk) begin
		if (id_wr.en) begin
			id_store[id_wr.addr] <= id_wr.data;
		end
	end

	// Pick the byte at the current job position
	always_comb begin
		id_off   = 5'(pos_q) - 5'(dgf_pkg::HDR_FIXED);
		cur_last = 1'b0;
		if (!job.hdr || pos_q == POS_W'(LAST_POS)) begin
			cur_byte = job.data;
			cur_last = 1'b1;
		end else if (pos_q == POS_W'(0)) begin
			cur_byte = job.frag_type;
		end else if (pos_q == POS_W'(1)) begin
			cur_byte = job.seq[7:0];
		end else if (pos_q == POS_W'(2)) begin
			cur_byte = job.seq[15:8];
		end else begin
			cur_byte = id_store[id_off[dgf_pkg::ID_AW-1:0]];
		end
	end

	// Advance position; restart for the next job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (job_valid && adv) begin
			pos_q <= cur_last ? '0 : pos_q + POS_W'(1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s2 <= 1'b0;
		end else if (adv) begin
			out_vld_s2 <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && job_valid) begin
			out_s2.out_byte     <= cur_byte;
			out_s2.datagram_end <= cur_last && job.dg_end;
			out_s2.run_last     <= cur_last;
		end
	end

endmodule

// File: rtl/core/dgf_checker.sv
// Port-level checks of the datagram fragmenter, bound to the top level.
// Depends on dgf_pkg.
module dgf_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          result_valid,
	input logic          result_stall,
	input dgf_pkg::out_t result,
	input logic          cfg_ready
);

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result beat changed");

	// Datagram end only on the last beat of an item
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.datagram_end |-> result.run_last)
		else $error("datagram end before last beat of item");

	// Header bytes follow without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !result.run_last |=> result_valid)
		else $error("gap inside an item's results");

	// Register port never blocks
	a_cfg_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("register port not ready");

endmodule

bind datagram_fragmenter dgf_checker u_dgf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result),
	.cfg_ready    (cfg_ready)
);
